// ===== sv/wtam_pkg.sv =====
// shared constants, types and helper function for the weekly alarm matcher
`timescale 1ns / 1ps

package wtam_pkg;

  localparam int unsigned MaxTimes     = 8;
  localparam int unsigned SlotCapacity = 8;
  localparam int unsigned SlotsPerWord = 4;
  localparam int unsigned SlotWidth    = 16;

  // day number = epoch / 86400 = (epoch >> 7) / 675
  localparam int unsigned SecondsPerDay = 24 * 3600;
  localparam int unsigned DayShift      = 7;
  localparam int unsigned DayOddFactor  = SecondsPerDay / (1 << DayShift);
  localparam int unsigned DivInWidth    = 32 - DayShift;
  localparam int unsigned DivRecipShift = 35;
  localparam int unsigned DivRecipWidth = 26;
  localparam logic [DivRecipWidth-1:0] DivRecip = 26'd50903317;
  localparam int unsigned DivProdWidth  = DivInWidth + DivRecipWidth;

  localparam int unsigned WeekdayShift = 5;

  localparam int unsigned CfgAddrWidth = 6;
  localparam int unsigned CfgDataWidth = 64;
  localparam int unsigned CfgIdxLsb    = 3;
  localparam int unsigned CfgIdxWidth  = CfgAddrWidth - CfgIdxLsb;

  localparam int unsigned InDataWidth  = 56;
  localparam int unsigned OutDataWidth = 8;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_ENABLE    = 3'd0,
    REG_DAY_MODE  = 3'd1,
    REG_DAY_MASK  = 3'd2,
    REG_TIME_CNT  = 3'd3,
    REG_SLOTS_LO  = 3'd4,
    REG_SLOTS_HI  = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DAY_MASK      = 2'd0,
    DAY_ODD       = 2'd1,
    DAY_EVEN      = 2'd2,
    DAY_ALTERNATE = 2'd3
  } day_mode_e;

  typedef struct packed {
    logic [2:0] weekday;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
    logic       sample_valid;
    logic [31:0] epoch_seconds;
  } sample_t;

  // (weekday + 5) mod 7, monday = 0
  function automatic logic [2:0] remap_weekday(input logic [2:0] wday);
    logic [2:0] dow;
    case (wday)
      3'd0:    dow = 3'd5;
      3'd1:    dow = 3'd6;
      3'd2:    dow = 3'd0;
      3'd3:    dow = 3'd1;
      3'd4:    dow = 3'd2;
      3'd5:    dow = 3'd3;
      3'd6:    dow = 3'd4;
      3'd7:    dow = 3'd5;
      default: dow = 3'd0;
    endcase
    return dow;
  endfunction

endpackage

// ===== sv/weekly_time_alarm_match.sv =====
// top level of the weekly alarm matcher: apb registers, sample register, match and result register
// an accepted sample passes the sample register, then the match logic into the result register
// throughput: one sample per cycle unless stalled; set by the two-register pipeline that stalls as a whole
// the day parity comes from one 25 x 26 bit reciprocal multiply in the match stage
// reset (rst_ni low, asynchronous): all but the sample register cleared, previous second set to 1, pipeline empty
`timescale 1ns / 1ps

module weekly_time_alarm_match #(
  parameter int unsigned MAX_TIMES = wtam_pkg::MaxTimes
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // sample stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // second[5:0] minute[11:6] hour[16:12] weekday[19:17] epoch[51:20] zeros[55:52]
  input  logic [wtam_pkg::InDataWidth-1:0]   s_axis_tdata,
  // sample_valid[0]
  input  logic                               s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // fire[0] zeros[7:1]
  output logic [wtam_pkg::OutDataWidth-1:0]  m_axis_tdata,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wtam_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [wtam_pkg::CfgDataWidth-1:0]  pwdata,
  output logic [wtam_pkg::CfgDataWidth-1:0]  prdata,
  output logic                               pready
);

  import wtam_pkg::*;

  logic                          enable_q;
  logic [1:0]                    day_mode_q;
  logic [6:0]                    day_mask_q;
  logic [3:0]                    time_count_q;
  logic [CfgDataWidth-1:0]       slots_lo_q;
  logic [CfgDataWidth-1:0]       slots_hi_q;

  logic                          cfg_we;
  cfg_reg_e                      cfg_idx;

  logic                          stage_en;
  logic                          in_valid_q;
  sample_t                       in_q;
  logic [5:0]                    prev_sec_q;
  logic                          out_valid_q;
  logic                          fire_q;

  logic                          fire_d;
  logic                          boundary;
  logic [2:0]                    dow;
  logic                          day_odd;
  logic                          day_ok;
  logic                          time_ok;
  logic [MAX_TIMES-1:0]          slot_hit;
  logic [DivProdWidth-1:0]       div_prod;
  logic [2*CfgDataWidth-1:0]     slots_all;

  // apb port
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = cfg_reg_e'(paddr[CfgAddrWidth-1:CfgIdxLsb]);

  always_comb begin
    case (cfg_idx)
      REG_ENABLE:   prdata = CfgDataWidth'(enable_q);
      REG_DAY_MODE: prdata = CfgDataWidth'(day_mode_q);
      REG_DAY_MASK: prdata = CfgDataWidth'(day_mask_q);
      REG_TIME_CNT: prdata = CfgDataWidth'(time_count_q);
      REG_SLOTS_LO: prdata = slots_lo_q;
      REG_SLOTS_HI: prdata = slots_hi_q;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      day_mode_q   <= 2'd0;
      day_mask_q   <= 7'd0;
      time_count_q <= 4'd0;
      slots_lo_q   <= '0;
      slots_hi_q   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ENABLE:   enable_q     <= pwdata[0];
        REG_DAY_MODE: day_mode_q   <= pwdata[1:0];
        REG_DAY_MASK: day_mask_q   <= pwdata[6:0];
        REG_TIME_CNT: time_count_q <= pwdata[3:0];
        REG_SLOTS_LO: slots_lo_q   <= pwdata;
        REG_SLOTS_HI: slots_hi_q   <= pwdata;
        default:      ;
      endcase
    end
  end

  // pipeline moves as a whole unless the result is stalled
  assign stage_en      = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = stage_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (stage_en) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en && s_axis_tvalid) begin
      in_q.second_of_minute <= s_axis_tdata[5:0];
      in_q.minute_of_hour   <= s_axis_tdata[11:6];
      in_q.hour_of_day      <= s_axis_tdata[16:12];
      in_q.weekday          <= s_axis_tdata[19:17];
      in_q.epoch_seconds    <= s_axis_tdata[51:20];
      in_q.sample_valid     <= s_axis_tuser;
    end
  end

  // match logic
  assign boundary = in_q.sample_valid & (prev_sec_q > in_q.second_of_minute);
  assign dow      = remap_weekday(in_q.weekday);
  assign div_prod = DivProdWidth'(in_q.epoch_seconds[31:DayShift])
                  * DivProdWidth'(DivRecip);
  assign day_odd  = div_prod[DivRecipShift];

  always_comb begin
    case (day_mode_e'(day_mode_q))
      DAY_MASK:      day_ok = day_mask_q[dow];
      DAY_ODD:       day_ok = dow[0];
      DAY_EVEN:      day_ok = ~dow[0];
      DAY_ALTERNATE: day_ok = ~day_odd;
      default:       day_ok = 1'b0;
    endcase
  end

  assign slots_all = {slots_hi_q, slots_lo_q};

  for (genvar i = 0; i < MAX_TIMES; i++) begin : g_slot
    assign slot_hit[i] = (time_count_q > 4'(i))
      & (slots_all[i*SlotWidth+8 +: 8] == {3'b000, in_q.hour_of_day})
      & (slots_all[i*SlotWidth   +: 8] == {2'b00, in_q.minute_of_hour});
  end

  assign time_ok = |slot_hit;
  assign fire_d  = boundary & enable_q & day_ok & time_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sec_q  <= 6'd1;
      out_valid_q <= 1'b0;
      fire_q      <= 1'b0;
    end else if (stage_en) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        fire_q <= fire_d;
        if (in_q.sample_valid) begin
          prev_sec_q <= in_q.second_of_minute;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataWidth'(fire_q);

endmodule

// ===== sv/wtam_checker.sv =====
// port-level checker for the weekly alarm matcher and its bind
`timescale 1ns / 1ps

module wtam_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic [wtam_pkg::OutDataWidth-1:0]  m_axis_tdata
);

  import wtam_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // input is blocked while the result is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted during output stall");

  // an accepted sample passes the sample register into the result register when the output drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("sample result missing");

  // only the fire bit may be set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataWidth-1:1] == '0)
    else $error("padding bits set in result");

endmodule

bind weekly_time_alarm_match wtam_checker u_wtam_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/weekly_time_alarm_match_tb.sv =====
// self-checking testbench for the weekly alarm matcher: directed table, then random clock samples
`timescale 1ns / 1ps

module weekly_time_alarm_match_tb;
  import wtam_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PhaseItems  = 165;
  localparam int unsigned PhaseCount  = 5;
  localparam int unsigned DayLength   = 86400;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DirRowCount = 39;

  typedef enum logic {
    ROW_CFG,
    ROW_SMP
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    cfg_reg_e    idx;
    logic [63:0] value;
    logic        valid;
    logic [5:0]  sec;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  wday;
    logic [31:0] epoch;
    logic        known;
    logic        fire;
  } dir_row_t;

  // register writes and samples; fire is given where it can be read off directly
  localparam dir_row_t DirRows [DirRowCount] = '{
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd0, 6'd0, 5'd0, 3'd1, 32'h0, 1'b1, 1'b0},
    '{ROW_CFG, REG_ENABLE, 64'h1, 1'b0, 6'd0, 6'd0, 5'd0, 3'd0, 32'h0, 1'b0, 1'b0},
    '{ROW_CFG, REG_DAY_MODE, 64'(DAY_MASK), 1'b0, 6'd0, 6'd0, 5'd0, 3'd0, 32'h0, 1'b0, 1'b0},
    '{ROW_CFG, REG_DAY_MASK, 64'h7f, 1'b0, 6'd0, 6'd0, 5'd0, 3'd0, 32'h0, 1'b0, 1'b0},
    '{ROW_CFG, REG_TIME_CNT, 64'h2, 1'b0, 6'd0, 6'd0, 5'd0, 3'd0, 32'h0, 1'b0, 1'b0},
    '{ROW_CFG, REG_SLOTS_LO, 64'h0000_0000_0000_173b, 1'b0, 6'd0, 6'd0, 5'd0, 3'd0, 32'h0,
      1'b0, 1'b0},
    '{ROW_CFG, REG_SLOTS_HI, 64'h0530_ffff_2000_003c, 1'b0, 6'd0, 6'd0, 5'd0, 3'd0, 32'h0,
      1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd59, 6'd0, 5'd0, 3'd1, 32'h0, 1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd0, 6'd59, 5'd23, 3'd7, 32'h0, 1'b1, 1'b1},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b0, 6'd5, 6'd0, 5'd0, 3'd1, 32'h0, 1'b1, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd0, 6'd0, 5'd0, 3'd0, 32'h0, 1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd60, 6'd0, 5'd0, 3'd1, 32'h0, 1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd0, 6'd0, 5'd0, 3'd0, 32'h0, 1'b1, 1'b1},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd30, 6'd0, 5'd0, 3'd1, 32'h0, 1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd0, 6'd48, 5'd5, 3'd2, 32'h0, 1'b0, 1'b0},
    '{ROW_CFG, REG_TIME_CNT, 64'hf, 1'b0, 6'd0, 6'd0, 5'd0, 3'd0, 32'h0, 1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd30, 6'd0, 5'd0, 3'd1, 32'h0, 1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd0, 6'd48, 5'd5, 3'd2, 32'h0, 1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd30, 6'd0, 5'd0, 3'd1, 32'h0, 1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd0, 6'd63, 5'd31, 3'd3, 32'hffff_ffff, 1'b0, 1'b0},
    '{ROW_CFG, REG_DAY_MODE, 64'(DAY_ODD), 1'b0, 6'd0, 6'd0, 5'd0, 3'd0, 32'h0, 1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd30, 6'd0, 5'd0, 3'd1, 32'h0, 1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd0, 6'd59, 5'd23, 3'd3, 32'h0, 1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd30, 6'd0, 5'd0, 3'd1, 32'h0, 1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd0, 6'd59, 5'd23, 3'd2, 32'h0, 1'b0, 1'b0},
    '{ROW_CFG, REG_DAY_MODE, 64'(DAY_EVEN), 1'b0, 6'd0, 6'd0, 5'd0, 3'd0, 32'h0, 1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd30, 6'd0, 5'd0, 3'd1, 32'h0, 1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd0, 6'd59, 5'd23, 3'd2, 32'h0, 1'b0, 1'b0},
    '{ROW_CFG, REG_DAY_MODE, 64'(DAY_ALTERNATE), 1'b0, 6'd0, 6'd0, 5'd0, 3'd0, 32'h0,
      1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd30, 6'd0, 5'd0, 3'd1, 32'h0, 1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd0, 6'd0, 5'd0, 3'd4, 32'd86400, 1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd30, 6'd0, 5'd0, 3'd1, 32'h0, 1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd0, 6'd0, 5'd0, 3'd4, 32'hffff_ffff, 1'b0, 1'b0},
    '{ROW_CFG, REG_DAY_MASK, 64'h0, 1'b0, 6'd0, 6'd0, 5'd0, 3'd0, 32'h0, 1'b0, 1'b0},
    '{ROW_CFG, REG_DAY_MODE, 64'(DAY_MASK), 1'b0, 6'd0, 6'd0, 5'd0, 3'd0, 32'h0, 1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd30, 6'd0, 5'd0, 3'd1, 32'h0, 1'b0, 1'b0},
    '{ROW_SMP, REG_ENABLE, 64'h0, 1'b1, 6'd0, 6'd59, 5'd23, 3'd7, 32'h0, 1'b0, 1'b0},
    '{ROW_CFG, REG_TIME_CNT, 64'h0, 1'b0, 6'd0, 6'd0, 5'd0, 3'd0, 32'h0, 1'b0, 1'b0},
    '{ROW_CFG, REG_ENABLE, 64'h0, 1'b0, 6'd0, 6'd0, 5'd0, 3'd0, 32'h0, 1'b0, 1'b0}
  };

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata  = '0;
  logic                    s_axis_tuser  = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    psel          = 1'b0;
  logic                    penable       = 1'b0;
  logic                    pwrite        = 1'b0;
  logic [CfgAddrWidth-1:0] paddr         = '0;
  logic [CfgDataWidth-1:0] pwdata        = '0;
  logic [CfgDataWidth-1:0] prdata;
  logic                    pready;

  // shadow of the register file and the remembered second
  logic         cfg_enable  = 1'b0;
  day_mode_e    cfg_mode    = DAY_MASK;
  logic [6:0]   cfg_mask    = '0;
  logic [3:0]   cfg_count   = '0;
  logic [127:0] cfg_slots   = '0;
  logic [5:0]   last_second = 6'd1;

  logic        fire_q [$];
  logic        fire_expected;
  int unsigned mismatches     = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  logic        hold_req       = 1'b0;
  int unsigned hold_left      = 0;

  // running wall clock for well-formed sample sequences
  int unsigned gen_sec   = 0;
  int unsigned gen_min   = 0;
  int unsigned gen_hour  = 0;
  int unsigned gen_wday  = 1;
  logic [31:0] gen_epoch = '0;

  weekly_time_alarm_match i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic predict_fire(input logic valid, input logic [5:0] sec,
                                        input logic [5:0] minute, input logic [4:0] hour,
                                        input logic [2:0] wday, input logic [31:0] epoch);
    logic [2:0]  dow;
    int unsigned limit;
    int unsigned k;
    logic        day_ok;
    logic        time_ok;
    logic        fire;
    logic [15:0] slot;
    day_ok  = 1'b0;
    time_ok = 1'b0;
    fire    = 1'b0;
    if (!valid) return 1'b0;
    if (last_second > sec) begin
      dow = 3'((32'(wday) + 5) % 7);
      case (cfg_mode)
        DAY_MASK: day_ok = cfg_mask[dow];
        DAY_ODD:  day_ok = dow[0];
        DAY_EVEN: day_ok = !dow[0];
        default:  day_ok = ((epoch / DayLength) % 2) == 0;
      endcase
      limit = (cfg_count > MaxTimes) ? MaxTimes : cfg_count;
      for (k = 0; k < limit; k++) begin
        slot = cfg_slots[16*k +: 16];
        if (slot[15:8] == {3'b0, hour} && slot[7:0] == {2'b0, minute}) time_ok = 1'b1;
      end
      fire = cfg_enable && day_ok && time_ok;
    end
    last_second = sec;
    return fire;
  endfunction

  task automatic cfg_write(input cfg_reg_e idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, {CfgIdxLsb{1'b0}}};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ENABLE:   cfg_enable = value[0];
      REG_DAY_MODE: cfg_mode   = day_mode_e'(value[1:0]);
      REG_DAY_MASK: cfg_mask   = value[6:0];
      REG_TIME_CNT: cfg_count  = value[3:0];
      REG_SLOTS_LO: cfg_slots[63:0]   = value;
      REG_SLOTS_HI: cfg_slots[127:64] = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // stop offering and wait until every pending fire flag has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (fire_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_sample(input logic valid, input logic [5:0] sec, input logic [5:0] minute,
                             input logic [4:0] hour, input logic [2:0] wday,
                             input logic [31:0] epoch, input logic known,
                             input logic known_fire);
    logic predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= valid;
    s_axis_tdata  <= {4'b0, epoch, wday, hour, minute, sec};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = predict_fire(valid, sec, minute, hour, wday, epoch);
    fire_q = {fire_q, (known ? known_fire : predicted)};
  endtask

  task automatic random_config(input int unsigned phase);
    logic [127:0] slots;
    logic [3:0]   count;
    logic [6:0]   mask;
    logic         enable;
    day_mode_e    mode;
    int unsigned  k;
    for (k = 0; k < SlotCapacity; k++) begin
      if ($urandom_range(0, 9) != 0)
        slots[16*k +: 16] = {3'b0, 5'($urandom_range(0, 23)), 2'b0, 6'($urandom_range(0, 59))};
      else
        slots[16*k +: 16] = 16'($urandom());
    end
    enable = 1'b1;
    mode   = (phase < 4) ? day_mode_e'(phase) : day_mode_e'($urandom_range(0, 3));
    mask   = 7'($urandom());
    count  = 4'($urandom_range(1, MaxTimes));
    case (phase)
      0: begin
        mask  = 7'h7f;
        count = 4'(MaxTimes);
      end
      1: begin
        mask  = 7'h0;
        count = 4'hf;
      end
      3: mask = 7'h7f;
      4: begin
        enable = ($urandom_range(0, 3) != 0);
        count  = 4'($urandom_range(0, 15));
      end
      default: ;
    endcase
    cfg_write(REG_ENABLE, 64'(enable));
    cfg_write(REG_DAY_MODE, 64'(mode));
    cfg_write(REG_DAY_MASK, 64'(mask));
    cfg_write(REG_TIME_CNT, 64'(count));
    cfg_write(REG_SLOTS_LO, slots[63:0]);
    cfg_write(REG_SLOTS_HI, slots[127:64]);
  endtask

  // mostly a clock that moves forward, often landing on a listed time at the minute boundary
  task automatic random_sample();
    int unsigned pick;
    int unsigned slot_idx;
    logic [15:0] slot;
    pick = $urandom_range(0, 99);
    if (pick < 16) begin
      send_sample(pick >= 8, 6'($urandom()), 6'($urandom()), 5'($urandom()), 3'($urandom()),
                  $urandom(), 1'b0, 1'b0);
    end else begin
      gen_sec += $urandom_range(1, 25);
      if (gen_sec > 60 || (gen_sec == 60 && $urandom_range(0, 3) != 0)) begin
        gen_sec = gen_sec % 60;
        if ($urandom_range(0, 99) < 60) begin
          slot_idx = $urandom_range(0, SlotCapacity - 1);
          slot     = cfg_slots[16*slot_idx +: 16];
          gen_hour = 32'(slot[12:8]);
          gen_min  = 32'(slot[5:0]);
        end else begin
          gen_hour = $urandom_range(0, 23);
          gen_min  = $urandom_range(0, 59);
        end
        gen_wday  = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 7);
        gen_epoch = $urandom();
      end
      send_sample(1'b1, 6'(gen_sec), 6'(gen_min), 5'(gen_hour), 3'(gen_wday), gen_epoch,
                  1'b0, 1'b0);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end else if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (fire_q.size() == 0) begin
        mismatches++;
        $display("%0t: result transaction with none pending, expected none, actual fire %0b",
                 $time, m_axis_tdata[0]);
      end else begin
        fire_expected = fire_q.pop_front();
        if (m_axis_tdata[0] !== fire_expected) begin
          mismatches++;
          $display("%0t: fire mismatch, expected %0b, actual %0b",
                   $time, fire_expected, m_axis_tdata[0]);
        end
      end
    end
  end

  initial begin
    int unsigned r;
    int unsigned phase;
    int unsigned item;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct   = 20;
    sink_stall_pct = 20;
    for (r = 0; r < DirRowCount; r++) begin
      if (DirRows[r].kind == ROW_CFG) begin
        drain();
        cfg_write(DirRows[r].idx, DirRows[r].value);
      end else begin
        send_sample(DirRows[r].valid, DirRows[r].sec, DirRows[r].minute, DirRows[r].hour,
                    DirRows[r].wday, DirRows[r].epoch, DirRows[r].known, DirRows[r].fire);
      end
    end

    for (phase = 0; phase < PhaseCount; phase++) begin
      drain();
      random_config(phase);
      case (phase)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 45;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 45;
        end
        3: begin
          src_idle_pct   = 26;
          sink_stall_pct = 26;
        end
        default: begin
          src_idle_pct   = 10;
          sink_stall_pct = 10;
        end
      endcase
      for (item = 0; item < PhaseItems; item++) begin
        // long receiver hold-off, then a full sender pause
        if (phase == PhaseCount - 1 && item == 40) hold_req = 1'b1;
        if (phase == PhaseCount - 1 && item == 110) drain();
        random_sample();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== weekly_time_alarm_match.f =====
sv/wtam_pkg.sv
sv/weekly_time_alarm_match.sv
sv/wtam_checker.sv
bench/weekly_time_alarm_match_tb.sv
